// ----- hdl/mxe_pkg.sv -----
// ----------------------------------------------------------------------------
// mxe_pkg: shared types and constants of the mini x86 instruction executor
// Instruction and result word layouts, operation and operand-kind codes,
// address generation and the fixed sizes used by more than one module.
// ----------------------------------------------------------------------------
`default_nettype none

package mxe_pkg;

	localparam int DATA_W        = 64;
	localparam int REG_NUM_W     = 4;
	localparam int SCALE_W       = 4;
	localparam int IB_W          = 8;
	localparam int MADDR_W       = 19;

	localparam int MEM_WORDS_DEF = 65536;
	localparam int NUM_REGS_DEF  = 16;

	localparam logic [REG_NUM_W-1:0] SP_REG     = 4'd4;
	localparam logic [DATA_W-1:0]    STACK_STEP = 64'h8;
	localparam logic [IB_W-1:0]      IB_RESET   = 8'd8;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_IB_IDX = '0;

	// Result queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OQ_PTR_W   = $clog2(OUTQ_DEPTH);
	localparam int OQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_MOV_RR = 3'd0,
		OP_MOV_RM = 3'd1,
		OP_MOV_MR = 3'd2,
		OP_ADD    = 3'd3,
		OP_PUSH   = 3'd4,
		OP_POP    = 3'd5,
		OP_CALL   = 3'd6,
		OP_RET    = 3'd7
	} op_t;

	// Operand forms; the memory forms name the address terms they add up.
	typedef enum logic [3:0] {
		KIND_NONE   = 4'd0,
		KIND_IMM    = 4'd1,
		KIND_REG    = 4'd2,
		KIND_M_D    = 4'd3,
		KIND_M_B    = 4'd4,
		KIND_M_DB   = 4'd5,
		KIND_M_BX   = 4'd6,
		KIND_M_DBX  = 4'd7,
		KIND_M_XS   = 4'd8,
		KIND_M_DXS  = 4'd9,
		KIND_M_BXS  = 4'd10,
		KIND_M_DBXS = 4'd11
	} kind_t;

	// Packed with the first field in the highest bits.
	typedef struct packed {
		logic [SCALE_W-1:0]   dst_scale;
		logic [REG_NUM_W-1:0] dst_index;
		logic [REG_NUM_W-1:0] dst_base;
		logic [DATA_W-1:0]    dst_imm;
		kind_t                dst_kind;
		logic [SCALE_W-1:0]   src_scale;
		logic [REG_NUM_W-1:0] src_index;
		logic [REG_NUM_W-1:0] src_base;
		logic [DATA_W-1:0]    src_imm;
		kind_t                src_kind;
		op_t                  operation;
	} instr_t;

	typedef struct packed {
		logic [DATA_W-1:0]    mem_value;
		logic [MADDR_W-1:0]   mem_address;
		logic                 mem_written;
		logic [DATA_W-1:0]    reg_value;
		logic [REG_NUM_W-1:0] written_reg;
		logic                 reg_written;
		logic [DATA_W-1:0]    stack_pointer;
		logic [DATA_W-1:0]    next_pc;
	} res_t;

	localparam int INS_W       = $bits(instr_t);
	localparam int RES_W       = $bits(res_t);
	localparam int IN_TDATA_W  = ((INS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	function automatic logic is_mem_kind(input kind_t k);
		return (k >= KIND_M_D) && (k <= KIND_M_DBXS);
	endfunction

	// Effective address: displacement + base + index or index * scale, mod 2^64.
	function automatic logic [DATA_W-1:0] eff_addr(
		input kind_t              k,
		input logic [DATA_W-1:0]  imm,
		input logic [DATA_W-1:0]  rb,
		input logic [DATA_W-1:0]  rx,
		input logic [SCALE_W-1:0] s
	);
		logic [DATA_W-1:0] t_imm;
		logic [DATA_W-1:0] t_base;
		logic [DATA_W-1:0] t_idx;
		logic [DATA_W-1:0] scaled;
		scaled = rx * DATA_W'(s);
		t_imm  = '0;
		t_base = '0;
		t_idx  = '0;
		case (k)
			KIND_M_D: begin
				t_imm = imm;
			end
			KIND_M_B: begin
				t_base = rb;
			end
			KIND_M_DB: begin
				t_imm  = imm;
				t_base = rb;
			end
			KIND_M_BX: begin
				t_base = rb;
				t_idx  = rx;
			end
			KIND_M_DBX: begin
				t_imm  = imm;
				t_base = rb;
				t_idx  = rx;
			end
			KIND_M_XS: begin
				t_idx = scaled;
			end
			KIND_M_DXS: begin
				t_imm = imm;
				t_idx = scaled;
			end
			KIND_M_BXS: begin
				t_base = rb;
				t_idx  = scaled;
			end
			KIND_M_DBXS: begin
				t_imm  = imm;
				t_base = rb;
				t_idx  = scaled;
			end
			default: begin
				t_imm = '0;
			end
		endcase
		return t_imm + t_base + t_idx;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/mxe_ram.sv -----
// ----------------------------------------------------------------------------
// mxe_ram: synchronous single-port-write, single-port-read memory
// Read data is registered; a read of the entry being written in the same
// cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module mxe_ram import mxe_pkg::*; #(
	parameter int DEPTH = NUM_REGS_DEF,
	parameter int WIDTH = DATA_W,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/mxe_outq.sv -----
// ----------------------------------------------------------------------------
// mxe_outq: result queue in front of the output stream
// A small first-in first-out queue; the executor only starts an instruction
// when a slot is certain to be free, so a push never finds it full.
// ----------------------------------------------------------------------------
`default_nettype none

module mxe_outq import mxe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  res_t                wr_res,
	output logic                rd_valid,
	input  logic                rd_ready,
	output res_t                rd_res,
	output logic [OQ_CNT_W-1:0] count
);

	res_t                ent_q [OUTQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                pop;

	assign rd_valid = (cnt_q != '0);
	assign pop      = rd_valid && rd_ready;
	assign rd_res   = ent_q[rd_ptr_q];
	assign count    = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_res;
		end
	end

	// A word pushed into an empty queue is offered unchanged on the next cycle.
	a_empty_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push && (cnt_q == '0) |=> rd_valid && (rd_res == $past(wr_res)))
		else $error("result pushed into empty queue not presented");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < OQ_CNT_W'(OUTQ_DEPTH)))
		else $error("result queue overflow");

endmodule

`default_nettype wire

// ----- hdl/mini_x86_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// mini_x86_instruction_executor: executes one decoded instruction per word
// Register file and data memory in synchronous RAMs, a four-stage pipeline
// with write-first forwarding, and a result queue on the output stream.
// ----------------------------------------------------------------------------
// The block takes one decoded instruction per input word and returns one
// result word for it: the new program counter, the stack pointer and any
// register or memory write. A new instruction is not accepted while the
// one before it is still in stage one; the limit is the register file, whose
// two read ports serve first the source base and index, then the destination
// base and index. From stage four each result word is pushed into a
// four-word queue that presents it on the output stream, so the
// input keeps running while the downstream side stalls, until the queue and
// the pipeline together hold four instructions. After reset the block
// clears the data memory (MEM_WORDS words, 65536 by default) and the
// register file to zero and accepts no instruction during that time; the
// instruction_bytes register can be written throughout. The data memory is
// addressed with aligned 64-bit words, the byte address divided by eight and
// taken modulo MEM_WORDS, which must be a power of two. Write
// instruction_bytes only while no instruction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module mini_x86_instruction_executor import mxe_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF,
	parameter int NUM_REGS  = NUM_REGS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// Instruction stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [2:0] operation, [6:3] src_kind, [70:7] src_imm, [74:71] src_base,
	// [78:75] src_index, [82:79] src_scale, [86:83] dst_kind,
	// [150:87] dst_imm, [154:151] dst_base, [158:155] dst_index,
	// [162:159] dst_scale, [167:163] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

	// Result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [63:0] next_pc, [127:64] stack_pointer, [128] reg_written,
	// [132:129] written_reg, [196:133] reg_value, [197] mem_written,
	// [216:198] mem_address, [280:217] mem_value, [287:281] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,

	// Configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready
);

	localparam int MAW = $clog2(MEM_WORDS);
	localparam int RAW = $clog2(NUM_REGS);

	// Register numbers at or above NUM_REGS read as zero; the stack pointer
	// lives in its own register and overrides the RAM copy of its entry.
	function automatic logic [DATA_W-1:0] reg_val(
		input logic [REG_NUM_W-1:0] num,
		input logic [DATA_W-1:0]    raw,
		input logic [DATA_W-1:0]    sp
	);
		logic [DATA_W-1:0] v;
		if (32'(num) >= NUM_REGS) begin
			v = '0;
		end else if (num == SP_REG) begin
			v = sp;
		end else begin
			v = raw;
		end
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Architectural state outside the RAMs
	// ------------------------------------------------------------------
	logic [IB_W-1:0]   ib_q;
	logic [DATA_W-1:0] pc_q;
	logic [DATA_W-1:0] sp_q;

	// Clearing pass after reset
	logic              clr_active_q;
	logic [MAW-1:0]    clr_cnt_q;
	logic              clr_rf;

	// Pipeline valids and payload
	logic              v_s1, v_s2, v_s3, v_s4;
	instr_t            ins_s1, ins_s2, ins_s3;
	logic [DATA_W-1:0] sreg_s3;
	logic [DATA_W-1:0] tgt_s3;
	res_t              res_s4;
	logic [MAW-1:0]    mword_s4;

	logic              in_accept;
	logic              cfg_write;
	logic [OQ_CNT_W-1:0] oq_count;
	logic [OQ_CNT_W-1:0] occupancy;
	res_t              oq_res;

	// RAM ports
	logic              rf_we;
	logic [RAW-1:0]    rf_waddr;
	logic [DATA_W-1:0] rf_wdata;
	logic [RAW-1:0]    rf_raddr_a, rf_raddr_b;
	logic [DATA_W-1:0] rf_rdata_a, rf_rdata_b;
	logic              dm_we;
	logic [MAW-1:0]    dm_waddr;
	logic [DATA_W-1:0] dm_wdata;
	logic [MAW-1:0]    dm_raddr;
	logic [DATA_W-1:0] dm_rdata;

	// Second-stage address generation
	logic [DATA_W-1:0] src_rb, src_rx, src_ea, call_tgt, rd_addr;

	// Execute stage
	logic [DATA_W-1:0] dst_rb, dst_rx, dst_ea;
	logic [DATA_W-1:0] sv_x, seq_x, next_x, sp_n_x, sp_out_x;
	logic              rw_x, mw_x;
	logic [REG_NUM_W-1:0] rnum_x;
	logic [DATA_W-1:0] rval_x, mval_x, maddr_x, mbyte_x;
	logic [MAW-1:0]    mword_x;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[PADDR_W-1:2] == REG_IB_IDX) ? PDATA_W'(ib_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ib_q <= IB_RESET;
		end else if (cfg_write && (paddr[PADDR_W-1:2] == REG_IB_IDX)) begin
			ib_q <= pwdata[IB_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Clearing pass: one data word per cycle, and the register file entries
	// alongside while the clearing counter is below NUM_REGS.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == MAW'(MEM_WORDS - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	assign clr_rf = clr_active_q && (32'(clr_cnt_q) < NUM_REGS);

	// ------------------------------------------------------------------
	// Input side. Each instruction uses the register file read ports in stages
	// one and two, so a new one is taken only when stage one is empty, and
	// only when its result is certain to find room in the queue.
	// ------------------------------------------------------------------
	assign occupancy = oq_count + OQ_CNT_W'(v_s2) + OQ_CNT_W'(v_s3) + OQ_CNT_W'(v_s4);
	assign s_axis_tready = !clr_active_q && !v_s1 && (occupancy < OQ_CNT_W'(OUTQ_DEPTH));
	assign in_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Register file: two copies sharing the write port give two reads per
	// cycle. Stage one reads source base and index, stage two destination
	// base and index. Both stages never hold an instruction at once.
	// ------------------------------------------------------------------
	assign rf_raddr_a = v_s2 ? ins_s2.dst_base[RAW-1:0]  : ins_s1.src_base[RAW-1:0];
	assign rf_raddr_b = v_s2 ? ins_s2.dst_index[RAW-1:0] : ins_s1.src_index[RAW-1:0];

	assign rf_we    = clr_active_q ? clr_rf : (v_s3 && rw_x);
	assign rf_waddr = clr_active_q ? clr_cnt_q[RAW-1:0] : rnum_x[RAW-1:0];
	assign rf_wdata = clr_active_q ? '0 : rval_x;

	mxe_ram #(
		.DEPTH (NUM_REGS),
		.WIDTH (DATA_W)
	) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_raddr_a),
		.rdata (rf_rdata_a)
	);

	mxe_ram #(
		.DEPTH (NUM_REGS),
		.WIDTH (DATA_W)
	) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_raddr_b),
		.rdata (rf_rdata_b)
	);

	// ------------------------------------------------------------------
	// Stage two: source address generation and the data memory read. The
	// previous instruction wrote its register in the cycle of our register
	// read, which the write-first RAM already returns; its stack pointer
	// update is already in sp_q.
	// ------------------------------------------------------------------
	always_comb begin
		src_rb = reg_val(ins_s2.src_base, rf_rdata_a, sp_q);
		src_rx = reg_val(ins_s2.src_index, rf_rdata_b, sp_q);
		src_ea = eff_addr(ins_s2.src_kind, ins_s2.src_imm, src_rb, src_rx,
			ins_s2.src_scale);
		if (ins_s2.src_kind == KIND_IMM) begin
			call_tgt = ins_s2.src_imm;
		end else if (ins_s2.src_kind == KIND_REG) begin
			call_tgt = src_rb;
		end else begin
			call_tgt = src_ea;
		end
		if ((ins_s2.operation == OP_POP) || (ins_s2.operation == OP_RET)) begin
			rd_addr = sp_q;
		end else begin
			rd_addr = src_ea;
		end
	end

	assign dm_raddr = rd_addr[MAW+2:3];

	// The store of the instruction ahead lands in the same cycle as this
	// read; the write-first memory forwards it.
	assign dm_we    = clr_active_q || (v_s4 && res_s4.mem_written);
	assign dm_waddr = clr_active_q ? clr_cnt_q : mword_s4;
	assign dm_wdata = clr_active_q ? '0 : res_s4.mem_value;

	mxe_ram #(
		.DEPTH (MEM_WORDS),
		.WIDTH (DATA_W)
	) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.raddr (dm_raddr),
		.rdata (dm_rdata)
	);

	// ------------------------------------------------------------------
	// Stage three: execute. Memory data and the destination registers
	// arrive; the register file, stack pointer and program counter are
	// updated at the end of this cycle.
	// ------------------------------------------------------------------
	always_comb begin
		dst_rb = reg_val(ins_s3.dst_base, rf_rdata_a, sp_q);
		dst_rx = reg_val(ins_s3.dst_index, rf_rdata_b, sp_q);
		dst_ea = eff_addr(ins_s3.dst_kind, ins_s3.dst_imm, dst_rb, dst_rx,
			ins_s3.dst_scale);

		if (ins_s3.src_kind == KIND_IMM) begin
			sv_x = ins_s3.src_imm;
		end else if (ins_s3.src_kind == KIND_REG) begin
			sv_x = sreg_s3;
		end else if (is_mem_kind(ins_s3.src_kind)) begin
			sv_x = dm_rdata;
		end else begin
			sv_x = '0;
		end

		seq_x   = pc_q + DATA_W'(ib_q);
		next_x  = seq_x;
		sp_n_x  = sp_q;
		rw_x    = 1'b0;
		rnum_x  = '0;
		rval_x  = '0;
		mw_x    = 1'b0;
		maddr_x = '0;
		mval_x  = '0;

		case (ins_s3.operation)
			OP_MOV_RR, OP_MOV_MR: begin
				if (ins_s3.dst_kind == KIND_REG) begin
					rw_x   = 1'b1;
					rnum_x = ins_s3.dst_base;
					rval_x = sv_x;
				end
			end
			OP_MOV_RM: begin
				if (is_mem_kind(ins_s3.dst_kind)) begin
					mw_x    = 1'b1;
					maddr_x = dst_ea;
					mval_x  = sv_x;
				end
			end
			OP_ADD: begin
				if (ins_s3.dst_kind == KIND_REG) begin
					rw_x   = 1'b1;
					rnum_x = ins_s3.dst_base;
					rval_x = dst_rb + sv_x;
				end
			end
			OP_PUSH: begin
				sp_n_x  = sp_q - STACK_STEP;
				mw_x    = 1'b1;
				maddr_x = sp_n_x;
				mval_x  = sv_x;
			end
			OP_POP: begin
				sp_n_x = sp_q + STACK_STEP;
				if (ins_s3.src_kind == KIND_REG) begin
					rw_x   = 1'b1;
					rnum_x = ins_s3.src_base;
					rval_x = dm_rdata;
				end
			end
			OP_CALL: begin
				sp_n_x  = sp_q - STACK_STEP;
				mw_x    = 1'b1;
				maddr_x = sp_n_x;
				mval_x  = seq_x;
				next_x  = tgt_s3;
			end
			OP_RET: begin
				next_x = dm_rdata;
				sp_n_x = sp_q + STACK_STEP;
			end
			default: begin
				next_x = seq_x;
			end
		endcase

		// Writes to registers that do not exist are dropped and not reported.
		if (rw_x && (32'(rnum_x) >= NUM_REGS)) begin
			rw_x   = 1'b0;
			rnum_x = '0;
			rval_x = '0;
		end

		// An explicit write to the stack pointer wins over the implicit step.
		if (rw_x && (rnum_x == SP_REG)) begin
			sp_out_x = rval_x;
		end else begin
			sp_out_x = sp_n_x;
		end

		mword_x = maddr_x[MAW+2:3];
		mbyte_x = DATA_W'(mword_x) << 3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			sp_q <= '0;
		end else if (v_s3) begin
			pc_q <= next_x;
			sp_q <= sp_out_x;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ins_s1 <= instr_t'(s_axis_tdata[INS_W-1:0]);
		end
		ins_s2  <= ins_s1;
		ins_s3  <= ins_s2;
		sreg_s3 <= src_rb;
		tgt_s3  <= call_tgt;
		res_s4.next_pc       <= next_x;
		res_s4.stack_pointer <= sp_out_x;
		res_s4.reg_written   <= rw_x;
		res_s4.written_reg   <= rnum_x;
		res_s4.reg_value     <= rval_x;
		res_s4.mem_written   <= mw_x;
		res_s4.mem_address   <= mw_x ? mbyte_x[MADDR_W-1:0] : '0;
		res_s4.mem_value     <= mval_x;
		mword_s4             <= mword_x;
	end

	// ------------------------------------------------------------------
	// Stage four: memory write and hand-over to the result queue.
	// ------------------------------------------------------------------
	mxe_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (v_s4),
		.wr_res   (res_s4),
		.rd_valid (m_axis_tvalid),
		.rd_ready (m_axis_tready),
		.rd_res   (oq_res),
		.count    (oq_count)
	);

	assign m_axis_tdata = OUT_TDATA_W'(oq_res);

	// No two adjacent pipeline stages hold instructions at once, which the
	// forwarding through the write-first RAMs relies on.
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && v_s2) && !(v_s2 && v_s3) && !(v_s3 && v_s4))
		else $error("instructions closer than two cycles in the pipeline");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !v_s1 && !v_s2 && !v_s3 && !v_s4)
		else $error("instruction in flight during memory clearing");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (oq_count < OQ_CNT_W'(OUTQ_DEPTH)))
		else $error("result reached a full queue");

endmodule

`default_nettype wire
